@@ sv/aidc_pkg.sv @@
package aidc_pkg;

    // Run length and converter resolution
    localparam int SAMPLE_RUN = 5;
    localparam int ADC_BITS   = 12;

    // Field widths fixed by the interface
    localparam int SAMPLE_W = 12;
    localparam int CFG_W    = 12;
    localparam int NUM_CFG  = 8;
    localparam int CFG_IDX_W = $clog2(NUM_CFG);

    // Accumulator and run counter widths
    localparam int TOTAL_W = $clog2(SAMPLE_RUN * (2 ** SAMPLE_W));
    localparam int IDX_W   = $clog2(SAMPLE_RUN);

    // Trimmed mean divides by the run length less two; done as a
    // reciprocal multiply that is exact for any TOTAL_W-bit dividend
    localparam int TRIM_DIV  = SAMPLE_RUN - 2;
    localparam int DIV_SHIFT = TOTAL_W + $clog2(TRIM_DIV);
    localparam int RECIP_W   = TOTAL_W + 1;
    localparam int PROD_W    = TOTAL_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(TRIM_DIV) - 64'd1) / 64'(TRIM_DIV));

    localparam logic [SAMPLE_W-1:0] ADC_MASK =
        SAMPLE_W'((64'd1 << ADC_BITS) - 64'd1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TV_LOW        = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TV_HIGH       = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_LINEOUT_LOW   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_LINEOUT_HIGH  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_CARMOUNT_LOW  = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_CARMOUNT_HIGH = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] CFG_OTG_LOW       = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] CFG_OTG_HIGH      = CFG_IDX_W'(7);

    // Dock line tracking: level 0 or 1, plus unknown after reset
    localparam logic [1:0] DOCK_LINE_UNKNOWN = 2'd3;

    typedef enum logic [1:0] {
        REQ_ID_LINE   = 2'd0,
        REQ_ADC       = 2'd1,
        REQ_DOCK_LINE = 2'd2
    } aidc_req_t;

    typedef enum logic [2:0] {
        EV_NONE        = 3'd0,
        EV_ACC_ATTACH  = 3'd1,
        EV_ACC_DETACH  = 3'd2,
        EV_DOCK_ATTACH = 3'd3,
        EV_DOCK_DETACH = 3'd4,
        EV_IGNORED     = 3'd5
    } aidc_event_t;

    typedef enum logic [1:0] {
        ACC_UNKNOWN   = 2'd0,
        ACC_TV        = 2'd1,
        ACC_AUDIO_OUT = 2'd2,
        ACC_CAR       = 2'd3
    } aidc_acc_t;

    typedef enum logic [1:0] {
        DOCK_NONE     = 2'd0,
        DOCK_CRADLE   = 2'd1,
        DOCK_KEYBOARD = 2'd2
    } aidc_dock_t;

    typedef struct packed {
        logic [1:0]          req_type;
        logic                line_level;
        logic [SAMPLE_W-1:0] adc_sample;
        logic                keyboard_present;
        logic                hdmi_active;
    } aidc_in_t;

    typedef struct packed {
        aidc_event_t         event_code;
        aidc_acc_t           accessory_kind;
        aidc_dock_t          dock_kind;
        logic [SAMPLE_W-1:0] mean_level;
        logic                otg_host;
        logic [5:0]          status_bits;
    } aidc_out_t;

    // Open window test, both bounds exclusive
    function automatic logic in_window(
        input logic [SAMPLE_W-1:0] v,
        input logic [CFG_W-1:0]    lo,
        input logic [CFG_W-1:0]    hi
    );
        return (v > lo) && (v < hi);
    endfunction

endpackage

@@ sv/accessory_id_classifier_unit.sv @@
// Channel  | Direction | Handshake            | Beat
// ---------+-----------+----------------------+---------------------------------
// req      | in        | req_valid/req_stall  | aidc_in_t: line or ADC sample
// rsp      | out       | rsp_valid/rsp_stall  | aidc_out_t: event and status word
// cfg      | in        | cfg_write_en         | cfg_index, cfg_data (window bounds)
//
// Each request beat gives exactly one response beat; it passes through the
// input register and then the result register. A new beat can be taken
// every cycle while req_stall is low; the state update, trimmed mean
// (one reciprocal multiply) and window compares fit in the single stage.
// req_stall rises only when both registers are full and rsp_stall is high.
// Reset idles the tracking state and loads the default window bounds.
module accessory_id_classifier_unit
    import aidc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  aidc_in_t             req_data,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output aidc_out_t            rsp_data,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // Pipeline registers
    logic      in_valid_reg, in_valid_next;
    aidc_in_t  in_data_reg;
    logic      out_valid_reg, out_valid_next;
    aidc_out_t out_data_reg, out_data_next;

    // Window bounds
    logic [CFG_W-1:0] cfg_reg [NUM_CFG];

    // Tracking state
    logic [1:0]          dock_line_reg, dock_line_next;
    logic                id_line_reg, id_line_next;
    aidc_acc_t           acc_type_reg, acc_type_next;
    aidc_dock_t          dock_type_reg, dock_type_next;
    logic                collecting_reg, collecting_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [SAMPLE_W-1:0] min_reg, min_next;
    logic [SAMPLE_W-1:0] max_reg, max_next;

    logic                in_take;
    logic                advance;
    logic [SAMPLE_W-1:0] sample;
    logic [TOTAL_W-1:0]  trimmed;
    logic [PROD_W-1:0]   product;
    logic [PROD_W-1:0]   mean_full;
    logic [SAMPLE_W-1:0] mean;

    // Handshake: input register drains into the result register
    assign advance   = in_valid_reg && (!out_valid_reg || !rsp_stall);
    assign req_stall = in_valid_reg && out_valid_reg && rsp_stall;
    assign in_take   = req_valid && !req_stall;
    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_data_reg;

    always_comb
    begin
        if (in_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (!rsp_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Trimmed mean from the updated run totals
    assign sample    = in_data_reg.adc_sample & ADC_MASK;
    assign trimmed   = total_next - TOTAL_W'(max_next) - TOTAL_W'(min_next);
    assign product   = PROD_W'(trimmed) * PROD_W'(RECIP);
    assign mean_full = product >> DIV_SHIFT;
    assign mean      = mean_full[SAMPLE_W-1:0];

    // Item processing and next state
    always_comb
    begin
        dock_line_next  = dock_line_reg;
        id_line_next    = id_line_reg;
        acc_type_next   = acc_type_reg;
        dock_type_next  = dock_type_reg;
        collecting_next = collecting_reg;
        idx_next        = idx_reg;
        total_next      = total_reg;
        min_next        = min_reg;
        max_next        = max_reg;

        out_data_next                = '0;
        out_data_next.event_code     = EV_NONE;
        out_data_next.accessory_kind = ACC_UNKNOWN;
        out_data_next.dock_kind      = DOCK_NONE;

        case (in_data_reg.req_type)
            REQ_ID_LINE:
            begin
                if (in_data_reg.line_level == id_line_reg) begin
                    out_data_next.event_code = EV_IGNORED;
                end else if (in_data_reg.line_level) begin
                    // detach, abandons any run in progress
                    id_line_next                 = 1'b1;
                    collecting_next              = 1'b0;
                    out_data_next.event_code     = EV_ACC_DETACH;
                    out_data_next.accessory_kind = acc_type_reg;
                end else begin
                    // fall starts a new sample run
                    id_line_next    = 1'b0;
                    collecting_next = 1'b1;
                    idx_next        = '0;
                    total_next      = '0;
                    min_next        = '0;
                    max_next        = '0;
                end
            end
            REQ_ADC:
            begin
                if (collecting_reg) begin
                    total_next = total_reg + TOTAL_W'(sample);
                    if (idx_reg == '0) begin
                        min_next = sample;
                        max_next = sample;
                    end else if (sample > max_reg) begin
                        max_next = sample;
                    end else if (sample < min_reg) begin
                        min_next = sample;
                    end
                    idx_next = idx_reg + IDX_W'(1);

                    // last sample of the run: classify
                    if (idx_reg == IDX_W'(SAMPLE_RUN - 1)) begin
                        collecting_next          = 1'b0;
                        out_data_next.mean_level = mean;
                        if (mean != '0) begin
                            if (in_window(mean, cfg_reg[CFG_TV_LOW], cfg_reg[CFG_TV_HIGH]))
                                acc_type_next = ACC_TV;
                            else if (in_window(mean, cfg_reg[CFG_LINEOUT_LOW],
                                               cfg_reg[CFG_LINEOUT_HIGH]))
                                acc_type_next = ACC_AUDIO_OUT;
                            else if (in_window(mean, cfg_reg[CFG_CARMOUNT_LOW],
                                               cfg_reg[CFG_CARMOUNT_HIGH]))
                                acc_type_next = ACC_CAR;
                            else
                                acc_type_next = ACC_UNKNOWN;
                            out_data_next.event_code = EV_ACC_ATTACH;
                        end else begin
                            // zero mean reads as offline
                            out_data_next.event_code = EV_ACC_DETACH;
                        end
                        out_data_next.accessory_kind = acc_type_next;
                        out_data_next.otg_host = in_window(mean, cfg_reg[CFG_OTG_LOW],
                                                           cfg_reg[CFG_OTG_HIGH]);
                    end
                end
            end
            REQ_DOCK_LINE:
            begin
                if (dock_line_reg == {1'b0, in_data_reg.line_level}) begin
                    out_data_next.event_code = EV_IGNORED;
                end else if (in_data_reg.line_level) begin
                    dock_line_next           = 2'd1;
                    out_data_next.event_code = EV_DOCK_DETACH;
                    out_data_next.dock_kind  = dock_type_reg;
                    dock_type_next           = DOCK_NONE;
                end else begin
                    dock_line_next           = 2'd0;
                    dock_type_next           = in_data_reg.keyboard_present ?
                                               DOCK_KEYBOARD : DOCK_CRADLE;
                    out_data_next.event_code = EV_DOCK_ATTACH;
                    out_data_next.dock_kind  = dock_type_next;
                end
            end
            default:
            begin
                out_data_next.event_code = EV_NONE;
            end
        endcase

        // Status word from the updated state and the hdmi_active input
        if (dock_line_next == 2'd0) begin
            out_data_next.status_bits[0] = (dock_type_next == DOCK_CRADLE);
            out_data_next.status_bits[1] = (dock_type_next == DOCK_KEYBOARD);
        end
        if (!id_line_next) begin
            out_data_next.status_bits[2] = (acc_type_next == ACC_CAR);
            out_data_next.status_bits[3] = (acc_type_next == ACC_TV);
            out_data_next.status_bits[4] = (acc_type_next == ACC_AUDIO_OUT);
        end
        out_data_next.status_bits[5] = in_data_reg.hdmi_active;
    end

    // Control and tracking registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            dock_line_reg  <= DOCK_LINE_UNKNOWN;
            id_line_reg    <= 1'b1;
            acc_type_reg   <= ACC_UNKNOWN;
            dock_type_reg  <= DOCK_NONE;
            collecting_reg <= 1'b0;
            idx_reg        <= '0;
            total_reg      <= '0;
            min_reg        <= '0;
            max_reg        <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                dock_line_reg  <= dock_line_next;
                id_line_reg    <= id_line_next;
                acc_type_reg   <= acc_type_next;
                dock_type_reg  <= dock_type_next;
                collecting_reg <= collecting_next;
                idx_reg        <= idx_next;
                total_reg      <= total_next;
                min_reg        <= min_next;
                max_reg        <= max_next;
            end
        end
    end

    // Window bounds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg[CFG_TV_LOW]        <= CFG_W'(2100);
            cfg_reg[CFG_TV_HIGH]       <= CFG_W'(2360);
            cfg_reg[CFG_LINEOUT_LOW]   <= CFG_W'(1100);
            cfg_reg[CFG_LINEOUT_HIGH]  <= CFG_W'(1360);
            cfg_reg[CFG_CARMOUNT_LOW]  <= CFG_W'(1590);
            cfg_reg[CFG_CARMOUNT_HIGH] <= CFG_W'(1840);
            cfg_reg[CFG_OTG_LOW]       <= CFG_W'(2600);
            cfg_reg[CFG_OTG_HIGH]      <= CFG_W'(2860);
        end else if (cfg_write_en) begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_data_reg <= req_data;
        if (advance)
            out_data_reg <= out_data_next;
    end

    // Checks
    a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (rsp_valid && rsp_stall))
        else $error("input stalled without output backpressure");

    a_run_needs_id_low: assert property (@(posedge clk) disable iff (!rst_n)
        collecting_reg |-> !id_line_reg)
        else $error("sample run active while ID line high");

    a_attach_has_mean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.event_code == EV_ACC_ATTACH) |-> rsp_data.mean_level != '0)
        else $error("attach reported with zero mean");

    a_dock_kind_on_dock_event: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.dock_kind != DOCK_NONE) |->
        (rsp_data.event_code == EV_DOCK_ATTACH || rsp_data.event_code == EV_DOCK_DETACH))
        else $error("dock kind on a non-dock event");

    a_otg_on_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.otg_host) |->
        (rsp_data.event_code == EV_ACC_ATTACH || rsp_data.event_code == EV_ACC_DETACH))
        else $error("OTG flag outside run completion");

    a_result_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> rsp_valid)
        else $error("processed beat did not reach the result register");

endmodule
